// ===== src/sctok_pkg.sv =====
`default_nettype none
package sctok_pkg;

  localparam int RES_POS_W = 12;

  localparam logic [1:0] KIND_ATTR = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [RES_POS_W-1:0] name_begin;
    logic [RES_POS_W-1:0] name_end;
    logic                 has_value;
    logic [RES_POS_W-1:0] value_begin;
    logic [RES_POS_W-1:0] value_end;
    logic [RES_POS_W-1:0] error_pos;
    logic                 final_res;
  } res_t;

endpackage
`default_nettype wire

// ===== src/sctok_parser.sv =====
`default_nettype none
module sctok_parser
  import sctok_pkg::*;
#(
  parameter int MAX_LEN = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] ch,
  output res_t            res0,
  output res_t            res1,
  output logic [1:0]      n_res
);

  localparam int POS_W = $clog2(MAX_LEN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_LEN - 1);

  localparam logic [2:0] ST_START     = 3'd0;
  localparam logic [2:0] ST_NAME      = 3'd1;
  localparam logic [2:0] ST_NAME_POST = 3'd2;
  localparam logic [2:0] ST_VALUE_PRE = 3'd3;
  localparam logic [2:0] ST_VALUE     = 3'd4;
  localparam logic [2:0] ST_QUOTED    = 3'd5;
  localparam logic [2:0] ST_TRAIL     = 3'd6;

  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  logic [2:0]       st_r, st_nxt;
  logic [POS_W-1:0] off_r, off_nxt;
  logic [POS_W-1:0] nb_r, nb_nxt;
  logic [POS_W-1:0] ne_r, ne_nxt;
  logic [POS_W-1:0] vb_r, vb_nxt;
  logic [POS_W-1:0] ve_r, ve_nxt;
  logic             dr_r, dr_nxt;

  logic             is_z, is_semi, is_eq, is_quote, is_ws, is_name;
  logic [POS_W-1:0] off_inc;
  logic             attr, done, err, a_hv;
  logic [POS_W-1:0] a_ne, a_vb, a_ve;

  assign is_z     = (ch == 8'd0);
  assign is_semi  = (ch == CH_SEMI);
  assign is_eq    = (ch == CH_EQ);
  assign is_quote = (ch == CH_QUOTE);
  assign is_ws    = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
  assign is_name  = (ch > 8'd32) && (ch < 8'd127) && !is_semi && !is_eq;
  assign off_inc  = (off_r < LAST_POS) ? off_r + 1'b1 : off_r;

  always_comb begin
    st_nxt  = st_r;
    off_nxt = off_r;
    nb_nxt  = nb_r;
    ne_nxt  = ne_r;
    vb_nxt  = vb_r;
    ve_nxt  = ve_r;
    dr_nxt  = dr_r;
    attr    = 1'b0;
    done    = 1'b0;
    err     = 1'b0;
    a_hv    = 1'b0;
    a_ne    = ne_r;
    a_vb    = vb_r;
    a_ve    = ve_r;
    if (step) begin
      if (dr_r) begin
        if (is_z) begin
          dr_nxt  = 1'b0;
          st_nxt  = ST_START;
          off_nxt = '0;
        end else begin
          off_nxt = off_inc;
        end
      end else if (!is_z && off_r >= LAST_POS) begin
        err = 1'b1;
      end else begin
        unique case (st_r)
          ST_START: begin
            if (is_z) begin
              done = 1'b1;
            end else if (is_ws) begin
              st_nxt = ST_START;
            end else if (is_name) begin
              nb_nxt = off_r;
              st_nxt = ST_NAME;
            end else begin
              err = 1'b1;
            end
          end
          ST_NAME: begin
            if (is_name) begin
              st_nxt = ST_NAME;
            end else if (is_z || is_semi || is_eq || is_ws) begin
              ne_nxt = off_r;
              a_ne   = off_r;
              if (is_z || is_semi) begin
                attr   = 1'b1;
                done   = is_z;
                st_nxt = ST_START;
              end else if (is_eq) begin
                st_nxt = ST_VALUE_PRE;
              end else begin
                st_nxt = ST_NAME_POST;
              end
            end else begin
              err = 1'b1;
            end
          end
          ST_NAME_POST: begin
            if (is_z || is_semi) begin
              attr   = 1'b1;
              done   = is_z;
              st_nxt = ST_START;
            end else if (is_eq) begin
              st_nxt = ST_VALUE_PRE;
            end else if (is_ws) begin
              st_nxt = ST_NAME_POST;
            end else begin
              err = 1'b1;
            end
          end
          ST_VALUE_PRE: begin
            if (is_z || is_semi) begin
              vb_nxt = off_r;
              ve_nxt = off_r;
              a_vb   = off_r;
              a_ve   = off_r;
              a_hv   = 1'b1;
              attr   = 1'b1;
              done   = is_z;
              st_nxt = ST_START;
            end else if (is_quote) begin
              vb_nxt = off_r + 1'b1;
              st_nxt = ST_QUOTED;
            end else if (is_ws) begin
              st_nxt = ST_VALUE_PRE;
            end else begin
              vb_nxt = off_r;
              st_nxt = ST_VALUE;
            end
          end
          ST_VALUE: begin
            if (is_z || is_semi || is_ws) begin
              ve_nxt = off_r;
              a_ve   = off_r;
              if (is_ws) begin
                st_nxt = ST_TRAIL;
              end else begin
                a_hv   = 1'b1;
                attr   = 1'b1;
                done   = is_z;
                st_nxt = ST_START;
              end
            end
          end
          ST_QUOTED: begin
            if (is_quote) begin
              ve_nxt = off_r;
              st_nxt = ST_TRAIL;
            end else if (is_z) begin
              err = 1'b1;
            end
          end
          ST_TRAIL: begin
            if (is_z || is_semi) begin
              a_hv   = 1'b1;
              attr   = 1'b1;
              done   = is_z;
              st_nxt = ST_START;
            end else if (!is_ws) begin
              st_nxt = ST_VALUE;
            end
          end
          default: begin
            st_nxt = ST_START;
          end
        endcase
      end

      if (!dr_r) begin
        if (err) begin
          st_nxt = ST_START;
          nb_nxt = '0;
          ne_nxt = '0;
          vb_nxt = '0;
          ve_nxt = '0;
          if (is_z) begin
            off_nxt = '0;
          end else begin
            dr_nxt  = 1'b1;
            off_nxt = off_inc;
          end
        end else if (done) begin
          st_nxt  = ST_START;
          off_nxt = '0;
          nb_nxt  = '0;
          ne_nxt  = '0;
          vb_nxt  = '0;
          ve_nxt  = '0;
        end else begin
          off_nxt = off_inc;
        end
      end
    end
  end

  always_comb begin
    res0 = '0;
    res1 = '0;
    res1.kind      = KIND_DONE;
    res1.final_res = 1'b1;
    if (attr) begin
      res0.kind       = KIND_ATTR;
      res0.name_begin = RES_POS_W'(nb_r);
      res0.name_end   = RES_POS_W'(a_ne);
      res0.has_value  = a_hv;
      res0.value_begin = a_hv ? RES_POS_W'(a_vb) : '0;
      res0.value_end   = a_hv ? RES_POS_W'(a_ve) : '0;
      res0.final_res  = !done;
    end else if (err) begin
      res0.kind      = KIND_ERR;
      res0.error_pos = RES_POS_W'(off_r);
      res0.final_res = 1'b1;
    end else begin
      res0.kind      = KIND_DONE;
      res0.final_res = 1'b1;
    end
    n_res = {1'b0, attr} + {1'b0, done} + {1'b0, err};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_START;
      off_r <= '0;
      nb_r  <= '0;
      ne_r  <= '0;
      vb_r  <= '0;
      ve_r  <= '0;
      dr_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      off_r <= off_nxt;
      nb_r  <= nb_nxt;
      ne_r  <= ne_nxt;
      vb_r  <= vb_nxt;
      ve_r  <= ve_nxt;
      dr_r  <= dr_nxt;
    end
  end

  a_zero_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_z) |=> (off_r == '0 && st_r == ST_START && !dr_r))
    else $error("terminator did not restart the parser");

  a_pair_is_attr_done: assert property (@(posedge clk) disable iff (!rst_n)
    (n_res == 2'd2) |-> (res0.kind == KIND_ATTR && !res0.final_res && !err))
    else $error("two results that are not attribute then done");

  a_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
    dr_r |-> (n_res == 2'd0))
    else $error("result while swallowing after an error");

  a_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= LAST_POS)
    else $error("offset past its saturation point");

endmodule
`default_nettype wire

// ===== src/sctok_res_fifo.sv =====
`default_nettype none
module sctok_res_fifo
  import sctok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] push_n,
  input  res_t            d0,
  input  res_t            d1,
  input  wire logic       pop,
  output logic            room2,
  output logic            head_vld,
  output res_t            head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  res_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             do_pop;

  assign head_vld = (cnt_r != '0);
  assign head     = mem_r[rd_r];
  assign room2    = (cnt_r <= (PTR_W+1)'(DEPTH - 2));
  assign do_pop   = pop && head_vld;

  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push_n);
    rd_nxt  = rd_r + PTR_W'(do_pop);
    cnt_nxt = cnt_r + (PTR_W+1)'(push_n) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= d0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_r + 1'b1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room2)
    else $error("push into a full result queue");

endmodule
`default_nettype wire

// ===== src/set_cookie_attr_tokenizer_unit.sv =====
`default_nettype none
// channel  dir  handshake             payload
// in_      in   in_valid / in_stall   in_ch
// out_     out  out_valid / out_stall out_kind, out_name_begin, out_name_end, out_has_value,
//                                     out_value_begin, out_value_end, out_error_pos,
//                                     out_final_res
// One byte a cycle while the queue has room (in_stall low): a byte is registered, then parsed
// and its 0..2 results are written to a four-entry result queue, whose head drives the outputs.
// The parser step is taken only while the queue has room for two results.
// rst_n (synchronous) returns the parser to the start state at offset 0 and empties the queue.
// out_stall backs up the queue, then the input register, then in_stall.
module set_cookie_attr_tokenizer_unit
  import sctok_pkg::*;
#(
  parameter int MAX_LEN = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_ch,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_kind,
  output logic [RES_POS_W-1:0]      out_name_begin,
  output logic [RES_POS_W-1:0]      out_name_end,
  output logic                      out_has_value,
  output logic [RES_POS_W-1:0]      out_value_begin,
  output logic [RES_POS_W-1:0]      out_value_end,
  output logic [RES_POS_W-1:0]      out_error_pos,
  output logic                      out_final_res
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] ch_r;
  logic       room2, step, accept;
  logic [1:0] n_res;
  res_t       res0, res1, head;

  assign step     = in_vld_r && room2;
  assign in_stall = in_vld_r && !room2;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r <= in_ch;
    end
  end

  sctok_parser #(
    .MAX_LEN (MAX_LEN)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (ch_r),
    .res0  (res0),
    .res1  (res1),
    .n_res (n_res)
  );

  sctok_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (n_res),
    .d0       (res0),
    .d1       (res1),
    .pop      (!out_stall),
    .room2    (room2),
    .head_vld (out_valid),
    .head     (head)
  );

  assign out_kind        = head.kind;
  assign out_name_begin  = head.name_begin;
  assign out_name_end    = head.name_end;
  assign out_has_value   = head.has_value;
  assign out_value_begin = head.value_begin;
  assign out_value_end   = head.value_end;
  assign out_error_pos   = head.error_pos;
  assign out_final_res   = head.final_res;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sctok_pkg::*;

  localparam int MAX_LEN      = 4096;
  localparam int LAST_POS     = MAX_LEN - 1;
  localparam int RANDOM_ITEMS = 1020;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 8;
  localparam int NUM_DIR      = 24;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [2:0] {
    P_START, P_NAME, P_NAME_POST, P_VALUE_PRE, P_VALUE, P_QUOTED, P_TRAIL
  } parse_st_e;

  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_DONE, ROW_ERR} row_chk_e;

  typedef struct packed {
    logic [7:0]           ch;
    row_chk_e             chk;
    logic [RES_POS_W-1:0] epos;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_ch = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_kind;
  logic [RES_POS_W-1:0] out_name_begin;
  logic [RES_POS_W-1:0] out_name_end;
  logic                 out_has_value;
  logic [RES_POS_W-1:0] out_value_begin;
  logic [RES_POS_W-1:0] out_value_end;
  logic [RES_POS_W-1:0] out_error_pos;
  logic                 out_final_res;

  set_cookie_attr_tokenizer_unit #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_ch(in_ch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_name_begin(out_name_begin),
    .out_name_end(out_name_end),
    .out_has_value(out_has_value),
    .out_value_begin(out_value_begin),
    .out_value_end(out_value_end),
    .out_error_pos(out_error_pos),
    .out_final_res(out_final_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // tokenizer state as seen by the predictor
  parse_st_e tk_state = P_START;
  int        tk_ofs = 0;
  int        tk_name_b = 0;
  int        tk_name_e = 0;
  int        tk_val_b = 0;
  int        tk_val_e = 0;
  bit        tk_has_val = 1'b0;
  bit        tk_swallow = 1'b0;

  res_t       step_res[$];
  res_t       row_res[$];
  res_t       tok_expected[$];
  logic [7:0] hdr[$];

  int n_mismatch = 0;
  int n_sent = 0;
  int hdr_cnt = 0;
  int n_attr_seen = 0;
  int n_done_seen = 0;
  int n_err_seen = 0;
  int burst_left = 0;
  bit valid_on = 1'b0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int rx_cycle = 0;
  bit tail_open = 1'b0;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{CH_END,   ROW_DONE, 12'd0},
    '{8'h01,    ROW_ERR,  12'd0},
    '{8'hFF,    ROW_NONE, 12'd0},
    '{CH_END,   ROW_NONE, 12'd0},
    '{CH_SP,    ROW_PRED, 12'd0},
    '{"!",      ROW_PRED, 12'd0},
    '{CH_EQ,    ROW_PRED, 12'd0},
    '{CH_QUOTE, ROW_PRED, 12'd0},
    '{"b",      ROW_PRED, 12'd0},
    '{CH_QUOTE, ROW_PRED, 12'd0},
    '{"x",      ROW_PRED, 12'd0},
    '{CH_SP,    ROW_PRED, 12'd0},
    '{CH_SEMI,  ROW_PRED, 12'd0},
    '{"~",      ROW_PRED, 12'd0},
    '{CH_TAB,   ROW_PRED, 12'd0},
    '{"d",      ROW_ERR,  12'd11},
    '{CH_END,   ROW_NONE, 12'd0},
    '{"k",      ROW_PRED, 12'd0},
    '{CH_EQ,    ROW_PRED, 12'd0},
    '{CH_END,   ROW_PRED, 12'd0},
    '{"q",      ROW_PRED, 12'd0},
    '{CH_EQ,    ROW_PRED, 12'd0},
    '{CH_QUOTE, ROW_PRED, 12'd0},
    '{CH_END,   ROW_ERR,  12'd3}
  };

  function automatic bit is_ws(input logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_name_char(input logic [7:0] c);
    return c > CH_SP && c < 8'd127 && c != CH_SEMI && c != CH_EQ;
  endfunction

  function automatic logic [7:0] pick_name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (c == CH_SEMI || c == CH_EQ);
    return c;
  endfunction

  function automatic logic [7:0] pick_value_char(input bit no_quote);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_ws(c) || c == CH_SEMI || (no_quote && c == CH_QUOTE));
    return c;
  endfunction

  task automatic add_token_result(input logic [1:0] kind, input int epos);
    res_t r;
    r = '0;
    r.kind = kind;
    if (kind == KIND_ATTR) begin
      r.name_begin = tk_name_b[RES_POS_W-1:0];
      r.name_end = tk_name_e[RES_POS_W-1:0];
      r.has_value = tk_has_val;
      if (tk_has_val) begin
        r.value_begin = tk_val_b[RES_POS_W-1:0];
        r.value_end = tk_val_e[RES_POS_W-1:0];
      end
    end
    r.error_pos = epos[RES_POS_W-1:0];
    step_res.push_back(r);
  endtask

  task automatic tk_clear_attr();
    tk_name_b = 0;
    tk_name_e = 0;
    tk_val_b = 0;
    tk_val_e = 0;
    tk_has_val = 1'b0;
  endtask

  task automatic tk_restart();
    tk_state = P_START;
    tk_ofs = 0;
    tk_swallow = 1'b0;
    tk_clear_attr();
  endtask

  task automatic tokenize_byte(input logic [7:0] c);
    int   pos;
    bit   consumed;
    bit   err;
    bit   hdr_done;
    res_t r;
    pos = tk_ofs;
    consumed = 1'b0;
    err = 1'b0;
    hdr_done = 1'b0;
    step_res.delete();
    if (tk_swallow) begin
      if (c == CH_END) tk_restart();
      else if (tk_ofs < LAST_POS) tk_ofs++;
      return;
    end
    if (c != CH_END && pos >= LAST_POS) begin
      err = 1'b1;
      consumed = 1'b1;
    end
    while (!consumed && !err) begin
      case (tk_state)
        P_START: begin
          if (c == CH_END) begin
            hdr_done = 1'b1;
            consumed = 1'b1;
          end else if (is_ws(c)) begin
            consumed = 1'b1;
          end else if (is_name_char(c)) begin
            tk_name_b = pos;
            tk_state = P_NAME;
          end else begin
            err = 1'b1;
          end
        end
        P_NAME: begin
          if (c == CH_END || c == CH_SEMI || c == CH_EQ || is_ws(c)) begin
            tk_name_e = pos;
            tk_state = P_NAME_POST;
          end else if (is_name_char(c)) begin
            consumed = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        P_NAME_POST: begin
          if (c == CH_END || c == CH_SEMI) begin
            tk_has_val = 1'b0;
            tk_val_b = 0;
            tk_val_e = 0;
            add_token_result(KIND_ATTR, 0);
            tk_state = P_START;
            consumed = (c != CH_END);
          end else if (c == CH_EQ) begin
            consumed = 1'b1;
            tk_state = P_VALUE_PRE;
          end else if (is_ws(c)) begin
            consumed = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        P_VALUE_PRE: begin
          tk_has_val = 1'b1;
          if (c == CH_END || c == CH_SEMI) begin
            tk_val_b = pos;
            tk_val_e = pos;
            add_token_result(KIND_ATTR, 0);
            tk_state = P_START;
            consumed = (c != CH_END);
          end else if (c == CH_QUOTE) begin
            consumed = 1'b1;
            tk_val_b = pos + 1;
            tk_state = P_QUOTED;
          end else if (is_ws(c)) begin
            consumed = 1'b1;
          end else begin
            tk_val_b = pos;
            tk_state = P_VALUE;
          end
        end
        P_VALUE: begin
          if (c == CH_END || c == CH_SEMI || is_ws(c)) begin
            tk_val_e = pos;
            tk_state = P_TRAIL;
          end else begin
            consumed = 1'b1;
          end
        end
        P_QUOTED: begin
          if (c == CH_QUOTE) begin
            tk_val_e = pos;
            consumed = 1'b1;
            tk_state = P_TRAIL;
          end else if (c == CH_END) begin
            err = 1'b1;
          end else begin
            consumed = 1'b1;
          end
        end
        P_TRAIL: begin
          if (c == CH_SEMI) begin
            add_token_result(KIND_ATTR, 0);
            tk_state = P_START;
            consumed = 1'b1;
          end else if (c == CH_END) begin
            add_token_result(KIND_ATTR, 0);
            tk_state = P_START;
          end else if (is_ws(c)) begin
            consumed = 1'b1;
          end else begin
            tk_state = P_VALUE;
          end
        end
        default: tk_state = P_START;
      endcase
    end
    if (err) begin
      add_token_result(KIND_ERR, pos);
      if (c == CH_END) begin
        tk_restart();
      end else begin
        tk_clear_attr();
        tk_state = P_START;
        tk_swallow = 1'b1;
        if (tk_ofs < LAST_POS) tk_ofs++;
      end
    end else if (hdr_done) begin
      add_token_result(KIND_DONE, 0);
      tk_restart();
    end else if (tk_ofs < LAST_POS) begin
      tk_ofs++;
    end
    if (step_res.size() > 0) begin
      r = step_res.pop_back();
      r.final_res = 1'b1;
      step_res.push_back(r);
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input bit typed);
    int gap;
    in_valid <= 1'b1;
    in_ch <= c;
    valid_on = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_byte(c);
    if (typed) foreach (row_res[k]) tok_expected.push_back(row_res[k]);
    else foreach (step_res[k]) tok_expected.push_back(step_res[k]);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_on = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_header();
    foreach (hdr[i]) send_byte(hdr[i], 1'b0);
  endtask

  task automatic pause_sender();
    if (valid_on) begin
      in_valid <= 1'b0;
      valid_on = 1'b0;
      @(posedge clk);
    end
    while (tok_expected.size() != 0) @(posedge clk);
  endtask

  task automatic add_ws();
    int r;
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        r = $urandom_range(0, 6);
        hdr.push_back((r == 6) ? CH_SP : CH_TAB + r[7:0]);
      end
    end
  endtask

  task automatic gen_header();
    int style;
    int form;
    int idx;
    hdr.delete();
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 12)) hdr.push_back(8'($urandom_range(1, 255)));
    end else begin
      for (int a = 0; a < $urandom_range(0, 4); a++) begin
        if (a > 0) begin
          hdr.push_back(CH_SEMI);
          add_ws();
        end
        add_ws();
        repeat ($urandom_range(1, 6)) hdr.push_back(pick_name_char());
        add_ws();
        if ($urandom_range(0, 3) != 0) begin
          hdr.push_back(CH_EQ);
          add_ws();
          form = $urandom_range(0, 5);
          if (form >= 1 && form <= 3) begin
            hdr.push_back(pick_value_char(1'b1));
            repeat ($urandom_range(0, 7)) begin
              if ($urandom_range(0, 5) == 0) add_ws();
              hdr.push_back(pick_value_char(1'b0));
            end
          end else if (form > 3) begin
            hdr.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
              do idx = $urandom_range(1, 255); while (idx == CH_QUOTE);
              hdr.push_back(idx[7:0]);
            end
            hdr.push_back(CH_QUOTE);
            if ($urandom_range(0, 3) == 0)
              repeat ($urandom_range(1, 3)) hdr.push_back(pick_value_char(1'b0));
          end
          add_ws();
        end
      end
      if ($urandom_range(0, 5) == 0) hdr.push_back(CH_SEMI);
      add_ws();
      if (style == 1 && hdr.size() > 0) begin
        idx = $urandom_range(0, hdr.size() - 1);
        if ($urandom_range(0, 1) == 0) hdr[idx] = 8'($urandom_range(1, 255));
        else while (hdr.size() > idx) void'(hdr.pop_back());
      end
    end
    hdr.push_back(CH_END);
  endtask

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= 30) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic cmp_field(input string fname, input logic [RES_POS_W-1:0] g,
                           input logic [RES_POS_W-1:0] e);
    if (g !== e) report_mismatch($sformatf("%s got %0h expected %0h", fname, g, e));
  endtask

  always @(posedge clk) begin : result_side
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_kind, out_name_begin, out_name_end, out_has_value, out_value_begin,
             out_value_end, out_error_pos, out_final_res};
      if (tok_expected.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with none outstanding", got.kind));
      end else begin
        want = tok_expected.pop_front();
        cmp_field("kind", RES_POS_W'(got.kind), RES_POS_W'(want.kind));
        cmp_field("name_begin", got.name_begin, want.name_begin);
        cmp_field("name_end", got.name_end, want.name_end);
        cmp_field("has_value", RES_POS_W'(got.has_value), RES_POS_W'(want.has_value));
        cmp_field("value_begin", got.value_begin, want.value_begin);
        cmp_field("value_end", got.value_end, want.value_end);
        cmp_field("error_pos", got.error_pos, want.error_pos);
        cmp_field("final_res", RES_POS_W'(got.final_res), RES_POS_W'(want.final_res));
      end
      if (got.kind == KIND_ATTR) n_attr_seen++;
      else if (got.kind == KIND_DONE) n_done_seen++;
      else n_err_seen++;
    end
    if (hold_asked != hold_served && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (tail_open) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (rx_cycle % 8 < 3);
      endcase
    end
    rx_cycle++;
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("no transaction for %0d cycles, %0d results outstanding", IDLE_LIMIT,
             tok_expected.size());
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    res_t r;
    int   rand_start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      row_res.delete();
      r = '0;
      r.final_res = 1'b1;
      case (dir_rows[i].chk)
        ROW_DONE: begin
          r.kind = KIND_DONE;
          row_res.push_back(r);
        end
        ROW_ERR: begin
          r.kind = KIND_ERR;
          r.error_pos = dir_rows[i].epos;
          row_res.push_back(r);
        end
        default: ;
      endcase
      send_byte(dir_rows[i].ch, dir_rows[i].chk != ROW_PRED);
    end
    pause_sender();
    rand_start = n_sent;
    while (n_sent - rand_start < RANDOM_ITEMS) begin
      hdr_cnt++;
      if (hdr_cnt == 12 || hdr_cnt == 90) hold_asked++;
      if (hdr_cnt % 40 == 0) pause_sender();
      gen_header();
      send_header();
    end
    pause_sender();
    tail_open = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d header bytes: the directed table, then %0d random headers",
             n_sent, hdr_cnt);
    $display("checked %0d attributes, %0d header ends, %0d syntax errors; %0d mismatches",
             n_attr_seen, n_done_seen, n_err_seen, n_mismatch);
    if (n_mismatch == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== set_cookie_attr_tokenizer_unit.f =====
src/sctok_pkg.sv
src/sctok_parser.sv
src/sctok_res_fifo.sv
src/set_cookie_attr_tokenizer_unit.sv
dv/testbench.sv
